>>> rtl/core/kte_pkg.sv
// Shared types and constants of the keystroke timing extractor.
package kte_pkg;

    localparam int KEY_W      = 7;
    localparam int CHAR_W     = 16;
    localparam int IN_TIME_W  = 32;
    localparam int OUT_TIME_W = 32;

    // Input word layout: key, char, time from the lowest bit up.
    localparam int S_KEY_LO  = 0;
    localparam int S_CHAR_LO = S_KEY_LO + KEY_W;
    localparam int S_TIME_LO = S_CHAR_LO + CHAR_W;
    localparam int S_USED_W  = S_TIME_LO + IN_TIME_W;
    localparam int S_DATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int S_USER_W  = 2;

    // Output word layout: key, char, flight, gap, hold from the lowest bit up.
    localparam int M_USED_W  = KEY_W + CHAR_W + 3 * OUT_TIME_W;
    localparam int M_DATA_W  = ((M_USED_W + 7) / 8) * 8;
    localparam int M_USER_W  = 1;

    localparam logic REQ_PRESS   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic capture;   // take the input word and read its table entry
        logic execute;   // apply the event and load a record if one is due
    } kte_cmd_t;

    typedef struct packed {
        logic emit;         // the held event completes a keystroke
        logic out_blocked;  // the output register is full and not being taken
    } kte_stat_t;

endpackage

>>> rtl/core/kte_ctrl.sv
// Controller state machine of the keystroke timing extractor.
module kte_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  kte_pkg::kte_stat_t stat,
    output kte_pkg::kte_cmd_t  cmd
);
    import kte_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // A record must wait until the previous one has left.
                if (!(stat.emit && stat.out_blocked))
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/kte_datapath.sv
// Datapath of the keystroke timing extractor: key table, timers and output register.
module kte_datapath
#(
    parameter int KEY_CODES = 128,
    parameter int TIME_BITS = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  kte_pkg::kte_cmd_t               cmd,
    output kte_pkg::kte_stat_t              stat,
    input  logic [kte_pkg::S_DATA_W-1:0]    s_axis_tdata,
    input  logic [kte_pkg::S_USER_W-1:0]    s_axis_tuser,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [kte_pkg::M_DATA_W-1:0]    m_axis_tdata,
    output logic [kte_pkg::M_USER_W-1:0]    m_axis_tuser
);
    import kte_pkg::*;

    // Only keys below both limits can ever be stored; only the low time bits matter.
    localparam int DEPTH = (KEY_CODES < (1 << KEY_W)) ? KEY_CODES : (1 << KEY_W);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int TW    = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;

    typedef struct packed {
        logic [TW-1:0] press;
        logic [TW-1:0] flight;
        logic [TW-1:0] gap;
    } entry_t;

    entry_t             mem [DEPTH];
    entry_t             rd_reg;
    logic [DEPTH-1:0]   valid_reg;

    logic               req_reg;
    logic               rep_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [TW-1:0]      time_reg;

    logic [TW-1:0]      last_press_reg;
    logic [TW-1:0]      last_rel_reg;
    logic               first_reg;
    logic               label_reg;

    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic               m_label_reg;

    logic [IDX_W-1:0]   s_idx;
    logic [IDX_W-1:0]   idx;
    logic               ignored;
    logic               is_press;
    logic               is_release;
    logic               hit;
    logic [TW-1:0]      flight;
    logic [TW-1:0]      gap;
    logic [TW-1:0]      hold;
    entry_t             wr_entry;

    assign s_idx = s_axis_tdata[S_KEY_LO +: IDX_W];
    assign idx   = key_reg[IDX_W-1:0];

    assign ignored    = rep_reg || (int'(key_reg) >= KEY_CODES);
    assign is_press   = !ignored && (req_reg == REQ_PRESS);
    assign is_release = !ignored && (req_reg == REQ_RELEASE);
    assign hit        = is_release && valid_reg[idx];

    assign flight = first_reg ? '0 : time_reg - last_rel_reg;
    assign gap    = first_reg ? '0 : time_reg - last_press_reg;
    assign hold   = time_reg - rd_reg.press;

    assign wr_entry.press  = time_reg;
    assign wr_entry.flight = flight;
    assign wr_entry.gap    = gap;

    assign stat.emit        = hit;
    assign stat.out_blocked = m_valid_reg && !m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_label_reg;

    // Input capture and table read happen together; the read data is ready for execute.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= s_axis_tuser[0];
            rep_reg  <= s_axis_tuser[1];
            key_reg  <= s_axis_tdata[S_KEY_LO +: KEY_W];
            char_reg <= s_axis_tdata[S_CHAR_LO +: CHAR_W];
            time_reg <= s_axis_tdata[S_TIME_LO +: TW];
            rd_reg   <= mem[s_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && is_press)
        begin
            mem[idx] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && hit)
        begin
            m_data_reg  <= M_DATA_W'({OUT_TIME_W'(hold), OUT_TIME_W'(rd_reg.gap),
                                      OUT_TIME_W'(rd_reg.flight), char_reg, key_reg});
            m_label_reg <= label_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            last_press_reg <= '0;
            last_rel_reg   <= '0;
            first_reg      <= 1'b1;
            label_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                label_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.execute)
            begin
                if (is_press)
                begin
                    last_press_reg <= time_reg;
                    valid_reg[idx] <= 1'b1;
                end
                if (is_release)
                begin
                    last_rel_reg <= time_reg;
                end
                if (hit)
                begin
                    valid_reg[idx] <= 1'b0;
                    first_reg      <= 1'b0;
                    m_valid_reg    <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/keystroke_timing_extractor_top.sv
// Top level of the keystroke timing extractor.

// Keystroke timing extractor. Each input word is one key event; a release that
// matches a stored press yields one output word carrying the hold time, the
// flight time since the previous release and the gap since the previous press,
// all in wrapping millisecond arithmetic, plus the session label. Autorepeat
// events and key codes at or above KEY_CODES leave no trace. An event goes through
// two steps: the capture step takes the word and reads the key's table entry
// from the registered memory port, the execute step applies the event and loads
// the output register. s_axis_tready is high in the cycle after an event
// finishes, and no new event is taken while one is in progress. A finished record
// waits in the output register without blocking the input; only a second record
// that is due while the first is still untaken holds the datapath until the
// first one is accepted. The per-key table needs no clearing after reset, since
// a valid bit per key guards every read. session_label may be written at any
// time the block holds no event in progress; records pick up its value at the
// time of their release.
module keystroke_timing_extractor_top
#(
    parameter int KEY_CODES = 128,
    parameter int TIME_BITS = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: key_code[6:0], char_code[22:7], time_ms[54:23], zero pad.
    input  logic [kte_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: req_type[0], is_autorepeat[1].
    input  logic [kte_pkg::S_USER_W-1:0]    s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: out_key[6:0], out_char[22:7], flight_ms[54:23],
    // gap_ms[86:55], hold_ms[118:87], zero pad.
    output logic [kte_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // Fields from bit 0: out_label[0].
    output logic [kte_pkg::M_USER_W-1:0]    m_axis_tuser,

    // Writes the session_label register.
    input  logic                            cfg_we,
    input  logic                            cfg_wdata
);
    import kte_pkg::*;

    kte_cmd_t  cmd;
    kte_stat_t stat;

    // The controller sequences capture and execute of each word.
    kte_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // The datapath holds the key table, the timers and the output register.
    kte_datapath
    #(
        .KEY_CODES (KEY_CODES),
        .TIME_BITS (TIME_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the keystroke timing extractor top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kte_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 4;
    // A clean run stays far inside this limit even with every stall at its longest.
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SHOWN_MISMATCHES = 10;
    // Room for the last event to pass both steps of the block and the output register.
    localparam int DRAIN_CYCLES     = 8;
    localparam int END_WAIT_LIMIT   = 4000;
    localparam int PHASES           = 6;
    localparam int PHASE_EVENTS     = 205;
    localparam int BURST_PAIRS      = 24;
    localparam int LONG_HOLD        = 300;
    localparam int KEY_COUNT        = 1 << KEY_W;

    // Offsets of the record fields inside m_axis_tdata.
    localparam int R_KEY_LO    = 0;
    localparam int R_CHAR_LO   = R_KEY_LO + KEY_W;
    localparam int R_FLIGHT_LO = R_CHAR_LO + CHAR_W;
    localparam int R_GAP_LO    = R_FLIGHT_LO + OUT_TIME_W;
    localparam int R_HOLD_LO   = R_GAP_LO + OUT_TIME_W;

    // Autorepeat flag carried in s_axis_tuser[1].
    localparam logic KEYED = 1'b0;
    localparam logic AUTO  = 1'b1;

    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [CHAR_W-1:0]    char_t;
    typedef logic [IN_TIME_W-1:0] ms_t;

    // One completed keystroke as the block reports it.
    typedef struct packed {
        key_t  key;
        char_t chr;
        ms_t   flight;
        ms_t   gap;
        ms_t   hold;
        logic  label;
    } keystroke_t;

    // One row of the directed table. Where pinned is set the record that the
    // event must produce is typed in the row itself.
    typedef struct packed {
        logic  kind;
        logic  rep;
        key_t  key;
        char_t chr;
        ms_t   stamp;
        logic  pinned;
        ms_t   flight;
        ms_t   gap;
        ms_t   hold;
    } event_row_t;

    // Directed events. They start right after reset, so the opening press gets
    // zero flight and gap, and every typed record carries the reset label 0.
    localparam event_row_t DIRECTED [22] = '{
        // A release before anything was pressed: no record, first press still pending.
        '{REQ_RELEASE, KEYED, 7'd9,   16'h0000, 32'd50,        1'b0, 32'd0, 32'd0, 32'd0},
        '{REQ_PRESS,   KEYED, 7'd0,   16'h0000, 32'd100,       1'b0, 32'd0, 32'd0, 32'd0},
        // Autorepeat events of a held key change nothing.
        '{REQ_PRESS,   AUTO,  7'd0,   16'h0000, 32'd120,       1'b0, 32'd0, 32'd0, 32'd0},
        '{REQ_RELEASE, AUTO,  7'd0,   16'h0000, 32'd130,       1'b0, 32'd0, 32'd0, 32'd0},
        // First record: flight and gap are still zero.
        '{REQ_RELEASE, KEYED, 7'd0,   16'h0041, 32'd150,       1'b1, 32'd0, 32'd0, 32'd50},
        // Release of a key that is not held only moves the last release time.
        '{REQ_RELEASE, KEYED, 7'd5,   16'h0000, 32'd200,       1'b0, 32'd0, 32'd0, 32'd0},
        // Highest key, with the hold time wrapping past zero.
        '{REQ_PRESS,   KEYED, 7'd127, 16'h0000, 32'hFFFF_FFF0, 1'b0, 32'd0, 32'd0, 32'd0},
        '{REQ_RELEASE, KEYED, 7'd127, 16'hFFFF, 32'h0000_0010, 1'b1,
          32'hFFFF_FF28, 32'hFFFF_FF8C, 32'h0000_0020},
        // A second press of a held key overwrites its entry.
        '{REQ_PRESS,   KEYED, 7'd10,  16'h0000, 32'h20,        1'b0, 32'd0, 32'd0, 32'd0},
        '{REQ_PRESS,   KEYED, 7'd10,  16'h0000, 32'h40,        1'b0, 32'd0, 32'd0, 32'd0},
        '{REQ_RELEASE, KEYED, 7'd10,  16'h1234, 32'h45,        1'b1, 32'h30, 32'h20, 32'h5},
        // Two keys pressed at the same instant, the second one released at once.
        '{REQ_PRESS,   KEYED, 7'd1,   16'h0000, 32'd1000,      1'b0, 32'd0, 32'd0, 32'd0},
        '{REQ_PRESS,   KEYED, 7'd2,   16'h0000, 32'd1000,      1'b0, 32'd0, 32'd0, 32'd0},
        '{REQ_RELEASE, KEYED, 7'd2,   16'h0000, 32'd1000,      1'b1, 32'h3A3, 32'd0, 32'd0},
        '{REQ_RELEASE, KEYED, 7'd1,   16'h8000, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0, 32'd0},
        // The entry was freed, so a second release gives nothing.
        '{REQ_RELEASE, KEYED, 7'd1,   16'h0000, 32'd5,         1'b0, 32'd0, 32'd0, 32'd0},
        // The character of a press is ignored; autorepeat does not overwrite.
        '{REQ_PRESS,   KEYED, 7'd127, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0, 32'd0},
        '{REQ_PRESS,   AUTO,  7'd127, 16'h0000, 32'd3,         1'b0, 32'd0, 32'd0, 32'd0},
        '{REQ_RELEASE, AUTO,  7'd127, 16'h0000, 32'd4,         1'b0, 32'd0, 32'd0, 32'd0},
        '{REQ_RELEASE, KEYED, 7'd127, 16'h7FFF, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0, 32'd0},
        // Half-range timestamps, with the longest possible hold.
        '{REQ_PRESS,   KEYED, 7'd64,  16'h0000, 32'h8000_0000, 1'b0, 32'd0, 32'd0, 32'd0},
        '{REQ_RELEASE, KEYED, 7'd64,  16'h5555, 32'h7FFF_FFFF, 1'b0, 32'd0, 32'd0, 32'd0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [S_USER_W-1:0] s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [M_USER_W-1:0] m_axis_tuser;
    logic                cfg_we;
    logic                cfg_wdata;

    // Timing state that the predictor keeps for itself.
    logic  label_reg;
    logic  awaiting_first;
    ms_t   prev_press_ms;
    ms_t   prev_release_ms;
    logic  key_held      [KEY_COUNT];
    ms_t   key_press_ms  [KEY_COUNT];
    ms_t   key_flight_ms [KEY_COUNT];
    ms_t   key_gap_ms    [KEY_COUNT];

    // Records still owed by the block, oldest first.
    keystroke_t pending_strokes [$];

    // A record typed into the directed table replaces the predicted one for
    // the next accepted word.
    logic       pin_next;
    keystroke_t pin_rec;

    // Coordination between the sender and the receiver.
    logic steady;
    logic hold_off_req;

    int   fault_count;
    int   events_sent;
    int   strokes_checked;
    int   cycle_count;

    keystroke_timing_extractor_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // Applies one accepted event to the predicted timing state. Returns 1 and
    // fills rec when the event completes a keystroke.
    function automatic logic time_keystroke(input logic kind, input logic rep,
                                            input key_t key, input char_t chr,
                                            input ms_t stamp, output keystroke_t rec);
        rec = '0;
        if (rep == AUTO)
            return 1'b0;
        if (kind == REQ_PRESS)
        begin
            // Flight and gap stay zero until the first keystroke has been reported.
            key_held[key]      = 1'b1;
            key_press_ms[key]  = stamp;
            key_flight_ms[key] = awaiting_first ? '0 : ms_t'(stamp - prev_release_ms);
            key_gap_ms[key]    = awaiting_first ? '0 : ms_t'(stamp - prev_press_ms);
            prev_press_ms      = stamp;
            return 1'b0;
        end
        prev_release_ms = stamp;
        if (!key_held[key])
            return 1'b0;
        awaiting_first = 1'b0;
        key_held[key]  = 1'b0;
        rec.key    = key;
        rec.chr    = chr;
        rec.flight = key_flight_ms[key];
        rec.gap    = key_gap_ms[key];
        rec.hold   = ms_t'(stamp - key_press_ms[key]);
        rec.label  = label_reg;
        return 1'b1;
    endfunction

    function automatic string describe(input keystroke_t r);
        return $sformatf("key=%0d char=%h flight=%h gap=%h hold=%h label=%0d",
                         r.key, r.chr, r.flight, r.gap, r.hold, r.label);
    endfunction

    // Everything on the two buses is sampled at the rising edge. The output
    // side is checked before the input side is predicted, so both happen in a
    // fixed order even though neither can affect the other in the same cycle.
    always @(posedge clk)
    begin
        keystroke_t seen;
        keystroke_t want;
        keystroke_t made;
        logic       due;

        if (!rst_n)
        begin
            label_reg       = 1'b0;
            awaiting_first  = 1'b1;
            prev_press_ms   = '0;
            prev_release_ms = '0;
            for (int k = 0; k < KEY_COUNT; k++)
                key_held[k] = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.key    = m_axis_tdata[R_KEY_LO +: KEY_W];
                seen.chr    = m_axis_tdata[R_CHAR_LO +: CHAR_W];
                seen.flight = m_axis_tdata[R_FLIGHT_LO +: OUT_TIME_W];
                seen.gap    = m_axis_tdata[R_GAP_LO +: OUT_TIME_W];
                seen.hold   = m_axis_tdata[R_HOLD_LO +: OUT_TIME_W];
                seen.label  = m_axis_tuser[0];
                if (pending_strokes.size() == 0)
                begin
                    if (fault_count < SHOWN_MISMATCHES)
                        $display("[%0t] record with none expected: %s", $realtime,
                                 describe(seen));
                    fault_count++;
                end
                else
                begin
                    want = pending_strokes.pop_front();
                    strokes_checked++;
                    if (seen.key !== want.key || seen.chr !== want.chr ||
                        seen.flight !== want.flight || seen.gap !== want.gap ||
                        seen.hold !== want.hold || seen.label !== want.label)
                    begin
                        if (fault_count < SHOWN_MISMATCHES)
                        begin
                            $display("[%0t] record differs", $realtime);
                            $display("    expected %s", describe(want));
                            $display("    actual   %s", describe(seen));
                        end
                        fault_count++;
                    end
                end
            end

            if (cfg_we)
                label_reg = cfg_wdata;

            if (s_axis_tvalid && s_axis_tready)
            begin
                events_sent++;
                due = time_keystroke(s_axis_tuser[0], s_axis_tuser[1],
                                     s_axis_tdata[S_KEY_LO +: KEY_W],
                                     s_axis_tdata[S_CHAR_LO +: CHAR_W],
                                     s_axis_tdata[S_TIME_LO +: IN_TIME_W], made);
                if (pin_next)
                begin
                    made     = pin_rec;
                    due      = 1'b1;
                    pin_next = 1'b0;
                end
                if (due)
                    pending_strokes.push_back(made);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles, %0d records still owed",
                     cycle_count, pending_strokes.size());
            $display("keystroke_timing_extractor_top: mismatch");
            $finish;
        end
    end

    // Receiver. It stalls in random bursts, once for a long stretch on request
    // from the sender, and never once the steady part of the run has begun.
    initial
    begin : sink
        int stall_left;
        int hold_left;

        stall_left    = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offers one event word and returns at the falling edge after it was taken.
    // It is always entered at a falling edge.
    task automatic send_event(input logic kind, input logic rep, input key_t key,
                              input char_t chr, input ms_t stamp);
        logic [S_DATA_W-1:0] word;

        word = '0;
        word[S_KEY_LO +: KEY_W]      = key;
        word[S_CHAR_LO +: CHAR_W]    = chr;
        word[S_TIME_LO +: IN_TIME_W] = stamp;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= {rep, kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic idle_input(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Holds the input back until every owed record has come out, then lets the
    // last event that produced nothing work its way through the block.
    task automatic settle();
        int waited;

        s_axis_tvalid <= 1'b0;
        for (waited = 0; pending_strokes.size() != 0 && waited < END_WAIT_LIMIT; waited++)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_label(input logic value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One random event. Most events form well-behaved keystrokes: a press of
    // any key, or the release of a key that is held. The rest is noise:
    // autorepeat words, releases of keys that may not be held, and presses
    // that may land on a held key.
    task automatic random_event(inout ms_t ms_clock);
        logic  kind;
        logic  rep;
        logic  found;
        key_t  key;
        char_t chr;
        int    roll;
        int    start;
        int    step;

        roll  = $urandom_range(0, 99);
        step  = $urandom_range(0, 99);
        kind  = REQ_PRESS;
        rep   = KEYED;
        found = 1'b0;
        key   = key_t'($urandom_range(0, KEY_COUNT - 1));
        chr   = char_t'($urandom_range(0, 16'hFFFF));

        // Time usually creeps forward; now and then it jumps far or anywhere.
        if (step < 80)
            ms_clock += $urandom_range(0, 400);
        else if (step < 95)
            ms_clock += $urandom_range(0, 100000);
        else
            ms_clock = $urandom();

        if (roll < 40)
        begin
            kind  = REQ_RELEASE;
            start = $urandom_range(0, KEY_COUNT - 1);
            for (int i = 0; i < KEY_COUNT; i++)
                if (!found && key_held[(start + i) % KEY_COUNT])
                begin
                    key   = key_t'((start + i) % KEY_COUNT);
                    found = 1'b1;
                end
        end
        else if (roll < 80)
            kind = REQ_PRESS;
        else if (roll < 90)
        begin
            rep  = AUTO;
            kind = 1'($urandom_range(0, 1));
        end
        else
            kind = 1'($urandom_range(0, 1));

        if (!steady && $urandom_range(0, 5) == 0)
            idle_input($urandom_range(1, 13));
        send_event(kind, rep, key, chr, ms_clock);
    endtask

    // Sender: reset, the directed table, then phases of random events with a
    // new session label written between phases while the block is idle.
    initial
    begin : stimulus
        event_row_t row;
        ms_t        ms_clock;
        key_t       key;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        pin_next      = 1'b0;
        pin_rec       = '0;
        steady        = 1'b0;
        hold_off_req  = 1'b0;
        fault_count     = 0;
        events_sent     = 0;
        strokes_checked = 0;
        cycle_count     = 0;
        ms_clock        = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            row = DIRECTED[i];
            if (row.pinned)
            begin
                // Still the label from reset.
                pin_rec  = '{key: row.key, chr: row.chr, flight: row.flight,
                             gap: row.gap, hold: row.hold, label: 1'b0};
                pin_next = 1'b1;
            end
            send_event(row.kind, row.rep, row.key, row.chr, row.stamp);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            // Alternate between the two label values, starting with 1.
            write_label(p % 2 == 0);
            // The final phase runs with no idling on either side.
            steady = (p == PHASES - 1);

            if (p == 2)
            begin
                // Hold the receiver off while back-to-back keystrokes pile up,
                // so the output register fills and the input stalls.
                hold_off_req = 1'b1;
                for (int j = 0; j < BURST_PAIRS; j++)
                begin
                    key = key_t'($urandom_range(0, KEY_COUNT - 1));
                    ms_clock += $urandom_range(1, 300);
                    send_event(REQ_PRESS, KEYED, key,
                               char_t'($urandom_range(0, 16'hFFFF)), ms_clock);
                    ms_clock += $urandom_range(0, 300);
                    send_event(REQ_RELEASE, KEYED, key,
                               char_t'($urandom_range(0, 16'hFFFF)), ms_clock);
                end
            end

            for (int j = 0; j < PHASE_EVENTS; j++)
                random_event(ms_clock);
        end

        settle();
        if (pending_strokes.size() != 0)
        begin
            $display("%0d records never came out", pending_strokes.size());
            fault_count += pending_strokes.size();
        end

        $display("%0d key events in %0d label phases with a long output stall, %0d records",
                 events_sent, PHASES, strokes_checked);
        $display("%0d faults", fault_count);
        if (fault_count == 0)
            $display("keystroke_timing_extractor_top: match");
        else
            $display("keystroke_timing_extractor_top: mismatch");
        $finish;
    end

endmodule
